// File: sv/stt_pkg.sv
// Tokenizer package: token codes, byte classes, operator and keyword lookup.
// Shared by the front classifier and the back scanner; depends on nothing.
package stt_pkg;

  localparam int unsigned OFFSET_BITS_DEF     = 20;
  localparam int unsigned LINE_BITS_DEF       = 16;
  localparam int unsigned KEYWORD_MAX_LEN_DEF = 8;
  localparam int unsigned IN_DEPTH_DEF        = 4;
  localparam int unsigned OUT_DEPTH_DEF       = 8;
  localparam int unsigned MAX_RECS            = 4;

  localparam logic [5:0] K_LPAREN    = 6'd0;
  localparam logic [5:0] K_RPAREN    = 6'd1;
  localparam logic [5:0] K_LBRACK    = 6'd2;
  localparam logic [5:0] K_RBRACK    = 6'd3;
  localparam logic [5:0] K_LBRACE    = 6'd4;
  localparam logic [5:0] K_RBRACE    = 6'd5;
  localparam logic [5:0] K_PLUS      = 6'd6;
  localparam logic [5:0] K_PLUS_EQ   = 6'd7;
  localparam logic [5:0] K_MINUS     = 6'd8;
  localparam logic [5:0] K_MINUS_EQ  = 6'd9;
  localparam logic [5:0] K_STAR      = 6'd10;
  localparam logic [5:0] K_STAR_EQ   = 6'd11;
  localparam logic [5:0] K_POWER     = 6'd12;
  localparam logic [5:0] K_SLASH     = 6'd13;
  localparam logic [5:0] K_SLASH_EQ  = 6'd14;
  localparam logic [5:0] K_PERCENT   = 6'd15;
  localparam logic [5:0] K_BANG      = 6'd16;
  localparam logic [5:0] K_BANG_EQ   = 6'd17;
  localparam logic [5:0] K_SEMI      = 6'd18;
  localparam logic [5:0] K_COLON     = 6'd19;
  localparam logic [5:0] K_DOT       = 6'd20;
  localparam logic [5:0] K_ASSIGN    = 6'd21;
  localparam logic [5:0] K_EQ_EQ     = 6'd22;
  localparam logic [5:0] K_LESS      = 6'd23;
  localparam logic [5:0] K_LESS_EQ   = 6'd24;
  localparam logic [5:0] K_GREATER   = 6'd25;
  localparam logic [5:0] K_GREATER_EQ = 6'd26;
  localparam logic [5:0] K_STRING    = 6'd27;
  localparam logic [5:0] K_CHARACTER = 6'd28;
  localparam logic [5:0] K_NUMBER    = 6'd29;
  localparam logic [5:0] K_IDENT     = 6'd30;
  localparam logic [5:0] K_KEYWORD0  = 6'd31;
  localparam logic [5:0] K_EOF       = 6'd53;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  typedef enum logic [3:0] {
    CL_SPACE, CL_LF, CL_HASH, CL_DQUOTE, CL_APOS, CL_DIGIT,
    CL_ALPHA, CL_OPER, CL_PUNCT, CL_OTHER
  } cls_e;

  typedef struct packed {
    logic       end_src;
    logic       present;
    logic [7:0] ch;
    cls_e       cls;
  } item_t;

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h28:   return K_LPAREN;
      8'h29:   return K_RPAREN;
      8'h5B:   return K_LBRACK;
      8'h5D:   return K_RBRACK;
      8'h7B:   return K_LBRACE;
      8'h7D:   return K_RBRACE;
      8'h25:   return K_PERCENT;
      8'h3B:   return K_SEMI;
      8'h3A:   return K_COLON;
      default: return K_DOT;
    endcase
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    case (c) inside
      8'h20, 8'h0D, 8'h09:                      return CL_SPACE;
      8'h0A:                                    return CL_LF;
      8'h23:                                    return CL_HASH;
      8'h22:                                    return CL_DQUOTE;
      8'h27:                                    return CL_APOS;
      [8'h30:8'h39]:                            return CL_DIGIT;
      [8'h41:8'h5A], [8'h61:8'h7A]:             return CL_ALPHA;
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h21, 8'h3D, 8'h3C, 8'h3E: return CL_OPER;
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h25, 8'h3B, 8'h3A, 8'h2E:
                                                return CL_PUNCT;
      default:                                  return CL_OTHER;
    endcase
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] p);
    case (p)
      8'h2B:   return K_PLUS;
      8'h2D:   return K_MINUS;
      8'h2A:   return K_STAR;
      8'h2F:   return K_SLASH;
      8'h21:   return K_BANG;
      8'h3D:   return K_ASSIGN;
      8'h3C:   return K_LESS;
      8'h3E:   return K_GREATER;
      default: return K_LPAREN;
    endcase
  endfunction

  // bit 6 flags a two-byte operator
  function automatic logic [6:0] op_double(input logic [7:0] p, input logic [7:0] c);
    if (c == CH_EQ) begin
      case (p)
        8'h2B:   return {1'b1, K_PLUS_EQ};
        8'h2D:   return {1'b1, K_MINUS_EQ};
        8'h2A:   return {1'b1, K_STAR_EQ};
        8'h2F:   return {1'b1, K_SLASH_EQ};
        8'h21:   return {1'b1, K_BANG_EQ};
        8'h3D:   return {1'b1, K_EQ_EQ};
        8'h3C:   return {1'b1, K_LESS_EQ};
        8'h3E:   return {1'b1, K_GREATER_EQ};
        default: return 7'd0;
      endcase
    end
    if (p == CH_STAR && c == CH_STAR) return {1'b1, K_POWER};
    return 7'd0;
  endfunction

  // pre holds the first eight bytes, first byte in the top bits
  function automatic logic [5:0] kw_kind(input logic [63:0] pre, input logic [3:0] len);
    if (len == 4'd3 && pre[63:40] == "and")      return K_KEYWORD0 + 6'd0;
    if (len == 4'd5 && pre[63:24] == "class")    return K_KEYWORD0 + 6'd1;
    if (len == 4'd5 && pre[63:24] == "const")    return K_KEYWORD0 + 6'd2;
    if (len == 4'd8 && pre[63:0]  == "continue") return K_KEYWORD0 + 6'd3;
    if (len == 4'd4 && pre[63:32] == "case")     return K_KEYWORD0 + 6'd4;
    if (len == 4'd4 && pre[63:32] == "else")     return K_KEYWORD0 + 6'd5;
    if (len == 4'd5 && pre[63:24] == "false")    return K_KEYWORD0 + 6'd6;
    if (len == 4'd3 && pre[63:40] == "for")      return K_KEYWORD0 + 6'd7;
    if (len == 4'd8 && pre[63:0]  == "function") return K_KEYWORD0 + 6'd8;
    if (len == 4'd2 && pre[63:48] == "if")       return K_KEYWORD0 + 6'd9;
    if (len == 4'd3 && pre[63:40] == "nil")      return K_KEYWORD0 + 6'd10;
    if (len == 4'd2 && pre[63:48] == "or")       return K_KEYWORD0 + 6'd11;
    if (len == 4'd6 && pre[63:16] == "return")   return K_KEYWORD0 + 6'd12;
    if (len == 4'd5 && pre[63:24] == "super")    return K_KEYWORD0 + 6'd13;
    if (len == 4'd6 && pre[63:16] == "switch")   return K_KEYWORD0 + 6'd14;
    if (len == 4'd4 && pre[63:32] == "this")     return K_KEYWORD0 + 6'd15;
    if (len == 4'd4 && pre[63:32] == "true")     return K_KEYWORD0 + 6'd16;
    if (len == 4'd3 && pre[63:40] == "var")      return K_KEYWORD0 + 6'd17;
    if (len == 4'd5 && pre[63:24] == "while")    return K_KEYWORD0 + 6'd18;
    if (len == 4'd7 && pre[63:8]  == "default")  return K_KEYWORD0 + 6'd19;
    if (len == 4'd2 && pre[63:48] == "do")       return K_KEYWORD0 + 6'd20;
    if (len == 4'd5 && pre[63:24] == "break")    return K_KEYWORD0 + 6'd21;
    return K_IDENT;
  endfunction

endpackage

// File: sv/stt_fifo.sv
// Small register queue, one word in per cycle while not full, one out while not empty.
// Generic; no package dependency.
module stt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == DEPTH_C);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: sv/stt_front.sv
// Front end: take the incoming byte, attach its character class, queue the item.
// Uses stt_pkg and stt_fifo.
module stt_front import stt_pkg::*; #(
  parameter int unsigned DEPTH = IN_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] text_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_source_i,
  input  logic       rd_i,
  output item_t      item_o,
  output logic       empty_o
);

  item_t item_in;
  logic [$bits(item_t)-1:0] rdata;

  always_comb begin
    item_in.end_src = end_of_source_i;
    item_in.present = byte_present_i;
    item_in.ch      = text_byte_i;
    item_in.cls     = classify(text_byte_i);
  end

  stt_fifo #(.WIDTH($bits(item_t)), .DEPTH(DEPTH)) u_in_q (
    .clk_i, .rst_ni,
    .wr_i(push_i), .wdata_i(item_in),
    .rd_i, .rdata_o(rdata),
    .full_o, .empty_o
  );

  assign item_o = item_t'(rdata);

endmodule

// File: sv/stt_lexer.sv
// Back end: scanner state machine, up to four token words per item, drained one
// word per cycle into the result queue while it is not full. Uses stt_pkg.
module stt_lexer import stt_pkg::*; #(
  parameter int unsigned OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS       = LINE_BITS_DEF,
  parameter int unsigned KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
  localparam int unsigned PW = OFFSET_BITS + 1,
  localparam int unsigned RW = 6 + 2 + OFFSET_BITS + PW + LINE_BITS + PW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  item_t         item_i,
  input  logic          item_empty_i,
  output logic          item_rd_o,
  output logic          rec_wr_o,
  output logic [RW-1:0] rec_o,
  input  logic          rec_full_i
);

  localparam int unsigned OB  = OFFSET_BITS;
  localparam int unsigned LB  = LINE_BITS;
  localparam int unsigned KIW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [PW-1:0] POS_CAP = {1'b1, {OB{1'b0}}};
  localparam logic [PW-1:0] KW_MAX  = PW'(KEYWORD_MAX_LEN);
  localparam logic [PW-1:0] KW_TAB  = PW'(8);

  localparam logic [3:0] M_IDLE = 4'd0, M_OP = 4'd1, M_COMMENT = 4'd2, M_STRING = 4'd3,
    M_CHAR1 = 4'd4, M_CHAR2 = 4'd5, M_NUMINT = 4'd6, M_NUMDOT = 4'd7, M_NUMFRAC = 4'd8,
    M_IDENT = 4'd9;

  logic [3:0]    mode_q, mode_d;
  logic [7:0]    pend_q, pend_d;
  logic [OB-1:0] ts_q, ts_d;
  logic [PW-1:0] off_q, off_d, col_q, col_d, sc_q, sc_d;
  logic [LB-1:0] ln_q, ln_d, sl_q, sl_d;
  logic [7:0]    kw_q [KEYWORD_MAX_LEN];
  logic [7:0]    kw_d [KEYWORD_MAX_LEN];

  logic [RW-1:0] recs [MAX_RECS];
  logic [RW-1:0] rec_q [MAX_RECS];
  logic [2:0]    n, cnt_q, idx_q;
  logic          take, have, push, do_idle, numdot_dot;
  logic [PW-1:0] idx, idx_e;
  logic [63:0]   pre, pre_e;
  logic [5:0]    id_kind;
  logic [6:0]    dbl;

  function automatic logic [PW-1:0] adv_off(input logic [PW-1:0] o);
    return (o < POS_CAP) ? o + 1'b1 : o;
  endfunction

  function automatic logic [PW-1:0] adv_col(input logic [PW-1:0] c, input logic [7:0] b);
    if (b == CH_LF) return PW'(1);
    return (c < POS_CAP) ? c + 1'b1 : c;
  endfunction

  function automatic logic [LB-1:0] adv_line(input logic [LB-1:0] l, input logic [7:0] b);
    return (b == CH_LF && l != {LB{1'b1}}) ? l + 1'b1 : l;
  endfunction

  function automatic logic [OB-1:0] sat_off(input logic [PW-1:0] o);
    return (o < POS_CAP) ? o[OB-1:0] : {OB{1'b1}};
  endfunction

  function automatic logic [RW-1:0] mk_tok(input logic [5:0] kind, input logic [1:0] err,
      input logic [PW-1:0] o, input logic [OB-1:0] s, input logic [LB-1:0] l,
      input logic [PW-1:0] c);
    return {(err != ERR_NONE) ? K_LPAREN : kind, err, s, o - {1'b0, s}, l, c, 1'b0};
  endfunction

  assign have      = (idx_q != cnt_q);
  assign push      = have && !rec_full_i;
  assign take      = !item_empty_i && (!have || (push && (idx_q + 3'd1 == cnt_q)));
  assign item_rd_o = take;
  assign rec_wr_o  = push;
  assign rec_o     = rec_q[idx_q[1:0]];

  // keyword lookup over the first eight prefix bytes
  always_comb begin
    for (int i = 0; i < 8; i++) pre[63-8*i -: 8] = kw_q[i];
    idx     = off_q - {1'b0, ts_q};
    id_kind = (idx > KW_TAB) ? K_IDENT : kw_kind(pre, idx[3:0]);
  end

  always_comb begin
    mode_d = mode_q; pend_d = pend_q; ts_d = ts_q; off_d = off_q; col_d = col_q;
    ln_d = ln_q; sl_d = sl_q; sc_d = sc_q;
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) kw_d[i] = kw_q[i];
    for (int i = 0; i < MAX_RECS; i++) recs[i] = '0;
    n = 3'd0;
    do_idle = 1'b0;
    numdot_dot = 1'b0;
    pre_e = '0;
    idx_e = '0;
    dbl = op_double(pend_q, item_i.ch);

    if (take && item_i.present) begin
      case (mode_q)
        M_IDLE: do_idle = 1'b1;
        M_OP: begin
          mode_d = M_IDLE;
          if (dbl[6]) begin
            off_d = adv_off(off_d); ln_d = adv_line(ln_d, item_i.ch);
            col_d = adv_col(col_d, item_i.ch);
            recs[n[1:0]] = mk_tok(dbl[5:0], ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
          end else begin
            recs[n[1:0]] = mk_tok(op_single(pend_q), ERR_NONE, off_d, ts_d, sl_d, sc_d);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (item_i.cls == CL_LF) begin
            mode_d = M_IDLE; do_idle = 1'b1;
          end else begin
            off_d = adv_off(off_d); col_d = adv_col(col_d, item_i.ch);
          end
        end
        M_STRING: begin
          off_d = adv_off(off_d); ln_d = adv_line(ln_d, item_i.ch);
          col_d = adv_col(col_d, item_i.ch);
          if (item_i.ch == CH_DQUOTE) begin
            recs[n[1:0]] = mk_tok(K_STRING, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
            mode_d = M_IDLE;
          end
        end
        M_CHAR1, M_CHAR2: begin
          off_d = adv_off(off_d); ln_d = adv_line(ln_d, item_i.ch);
          col_d = adv_col(col_d, item_i.ch);
          if (mode_q == M_CHAR1) begin
            mode_d = M_CHAR2;
          end else begin
            recs[n[1:0]] = mk_tok(K_CHARACTER, ERR_NONE, off_d, ts_d, sl_d, sc_d);
            n = n + 3'd1;
            mode_d = M_IDLE;
          end
        end
        M_NUMINT, M_NUMFRAC: begin
          if (item_i.cls == CL_DIGIT) begin
            off_d = adv_off(off_d); col_d = adv_col(col_d, item_i.ch);
          end else if (mode_q == M_NUMINT && item_i.ch == CH_DOT) begin
            mode_d = M_NUMDOT;
          end else begin
            recs[n[1:0]] = mk_tok(K_NUMBER, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
            mode_d = M_IDLE; do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (item_i.cls == CL_DIGIT) begin
            off_d = adv_off(adv_off(off_d));
            col_d = adv_col(adv_col(col_d, CH_DOT), item_i.ch);
            mode_d = M_NUMFRAC;
          end else begin
            recs[n[1:0]] = mk_tok(K_NUMBER, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
            mode_d = M_IDLE; numdot_dot = 1'b1; do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (item_i.cls == CL_ALPHA || item_i.cls == CL_DIGIT) begin
            if (idx < KW_MAX) kw_d[idx[KIW-1:0]] = item_i.ch;
            off_d = adv_off(off_d); col_d = adv_col(col_d, item_i.ch);
          end else begin
            recs[n[1:0]] = mk_tok(id_kind, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
            mode_d = M_IDLE; do_idle = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE; do_idle = 1'b1;
        end
      endcase

      // the held dot becomes a token of its own
      if (numdot_dot) begin
        ts_d = sat_off(off_d); sl_d = ln_d; sc_d = col_d;
        off_d = adv_off(off_d); col_d = adv_col(col_d, CH_DOT);
        recs[n[1:0]] = mk_tok(K_DOT, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
      end

      if (do_idle) begin
        ts_d = sat_off(off_d); sl_d = ln_d; sc_d = col_d;
        off_d = adv_off(off_d); ln_d = adv_line(ln_d, item_i.ch);
        col_d = adv_col(col_d, item_i.ch);
        case (item_i.cls)
          CL_PUNCT: begin
            recs[n[1:0]] = mk_tok(punct_kind(item_i.ch), ERR_NONE, off_d, ts_d, sl_d, sc_d);
            n = n + 3'd1;
          end
          CL_OPER: begin
            pend_d = item_i.ch; mode_d = M_OP;
          end
          CL_SPACE, CL_LF: ;
          CL_HASH:   mode_d = M_COMMENT;
          CL_DQUOTE: mode_d = M_STRING;
          CL_APOS:   mode_d = M_CHAR1;
          CL_DIGIT:  mode_d = M_NUMINT;
          CL_ALPHA: begin
            kw_d[0] = item_i.ch; mode_d = M_IDENT;
          end
          default: begin
            recs[n[1:0]] = mk_tok(K_LPAREN, ERR_UNEXPECTED, off_d, ts_d, sl_d, sc_d);
            n = n + 3'd1;
          end
        endcase
      end
    end

    // end of source: flush the open token, close with end of file, restart
    if (take && item_i.end_src) begin
      case (mode_d)
        M_OP: begin
          recs[n[1:0]] = mk_tok(op_single(pend_d), ERR_NONE, off_d, ts_d, sl_d, sc_d);
          n = n + 3'd1;
        end
        M_STRING: begin
          recs[n[1:0]] = mk_tok(K_LPAREN, ERR_UNTERM, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
        end
        M_NUMINT, M_NUMFRAC, M_NUMDOT: begin
          recs[n[1:0]] = mk_tok(K_NUMBER, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
          if (mode_d == M_NUMDOT) begin
            ts_d = sat_off(off_d); sl_d = ln_d; sc_d = col_d;
            off_d = adv_off(off_d); col_d = adv_col(col_d, CH_DOT);
            recs[n[1:0]] = mk_tok(K_DOT, ERR_NONE, off_d, ts_d, sl_d, sc_d); n = n + 3'd1;
          end
        end
        M_IDENT: begin
          // prefix and length taken after this item's byte
          for (int i = 0; i < 8; i++) pre_e[63-8*i -: 8] = kw_d[i];
          idx_e = off_d - {1'b0, ts_d};
          recs[n[1:0]] = mk_tok((idx_e > KW_TAB) ? K_IDENT : kw_kind(pre_e, idx_e[3:0]),
                                ERR_NONE, off_d, ts_d, sl_d, sc_d);
          n = n + 3'd1;
        end
        default: ;
      endcase
      recs[n[1:0]] = {K_EOF, ERR_NONE, sat_off(off_d), {PW{1'b0}}, ln_d, col_d, 1'b1};
      n = n + 3'd1;
      mode_d = M_IDLE; pend_d = '0; ts_d = '0; off_d = '0;
      ln_d = LB'(1); col_d = PW'(1); sl_d = LB'(1); sc_d = PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) kw_q[i] <= kw_d[i];
    if (take) begin
      for (int i = 0; i < MAX_RECS; i++) rec_q[i] <= recs[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      ts_q   <= '0;
      off_q  <= '0;
      ln_q   <= LB'(1);
      col_q  <= PW'(1);
      sl_q   <= LB'(1);
      sc_q   <= PW'(1);
      cnt_q  <= '0;
      idx_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      ts_q   <= ts_d;
      off_q  <= off_d;
      ln_q   <= ln_d;
      col_q  <= col_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
      if (take) begin
        cnt_q <= n;
        idx_q <= '0;
      end else if (push) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

// File: sv/source_text_tokenizer_unit.sv
// Source text tokenizer, top level.
// Bytes go in through a queue-like port: present a byte with push while full is
// low. byte_present low with end_of_source high closes the text without a byte;
// both low is an idle item. Token words come out the same way: while empty is
// low the oldest token is on the result ports, and pop takes it.
// A token word reaches the result ports through the input queue, the scanner's
// token registers and the result queue, each of which holds it registered.
// Throughput is one byte per cycle while each byte closes at most one token and
// the result queue is not full; a byte that closes more tokens (at most four)
// holds the scanner until the single write port of the result queue takes them.
// The end-of-file word, with last_result set, closes each text, and the scanner
// returns to its reset state so that the next byte opens a new text.
// Reset clears both queues and the scanner: offset 0, line 1, column 1.
// When pop stays low the result queue fills, the scanner stops, the input queue
// fills and full rises; nothing is lost.
// Uses stt_pkg, stt_front, stt_lexer and stt_fifo.
module source_text_tokenizer_unit import stt_pkg::*; #(
  parameter int unsigned OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS       = LINE_BITS_DEF,
  parameter int unsigned KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             text_byte_i,
  input  logic                   byte_present_i,
  input  logic                   end_of_source_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [5:0]             token_kind_o,
  output logic [1:0]             error_code_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS:0]   token_length_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [OFFSET_BITS:0]   column_number_o,
  output logic                   last_result_o
);

  localparam int unsigned PW = OFFSET_BITS + 1;
  localparam int unsigned RW = 6 + 2 + OFFSET_BITS + PW + LINE_BITS + PW + 1;

  item_t         item;
  logic          item_empty, item_rd, rec_wr, rec_full;
  logic [RW-1:0] rec_in, rec_out;

  stt_front #(.DEPTH(IN_DEPTH_DEF)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .text_byte_i, .byte_present_i, .end_of_source_i,
    .rd_i(item_rd), .item_o(item), .empty_o(item_empty)
  );

  stt_lexer #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_lexer (
    .clk_i, .rst_ni,
    .item_i(item), .item_empty_i(item_empty), .item_rd_o(item_rd),
    .rec_wr_o(rec_wr), .rec_o(rec_in), .rec_full_i(rec_full)
  );

  stt_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH_DEF)) u_out_q (
    .clk_i, .rst_ni,
    .wr_i(rec_wr), .wdata_i(rec_in),
    .rd_i(pop), .rdata_o(rec_out),
    .full_o(rec_full), .empty_o(empty)
  );

  assign {token_kind_o, error_code_o, start_offset_o, token_length_o,
          line_number_o, column_number_o, last_result_o} = rec_out;

endmodule
